// ===== src/gbl_pkg.sv =====
// Shared constants, types and helpers for the glyph row blitter.
// Used by the top level and the port checker; depends on nothing else.
`default_nettype none
package gbl_pkg;

  localparam int WIDTH       = 32;
  localparam int HEIGHT      = 24;
  localparam int STORE_WORDS = WIDTH * HEIGHT;
  localparam int ADDR_W      = $clog2(STORE_WORDS);
  localparam int COL_W       = $clog2(WIDTH);
  localparam int COLOR_W     = 32;

  localparam int         GLYPH_COLS = 8;
  localparam logic [7:0] LEFT_MASK  = 8'h80;

  // Reciprocals for the constant modulo: q = (m * RCP) >> RCP_SH is exact for m <= 255.
  localparam int RCP_SH = 16;
  localparam int RCP_W  = (1 << RCP_SH) / WIDTH + 1;
  localparam int RCP_H  = (1 << RCP_SH) / HEIGHT + 1;

  localparam logic signed [8:0] WIDTH_S  = 9'(WIDTH);
  localparam logic signed [8:0] HEIGHT_S = 9'(HEIGHT);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_WORDS - 1);

  typedef enum logic [1:0] {
    KIND_FILL = 2'd0,
    KIND_DRAW = 2'd1,
    KIND_READ = 2'd2
  } gbl_kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_MOD_Y,
    ST_MOD_X,
    ST_ROW_BASE,
    ST_DRAW,
    ST_READ_WAIT,
    ST_FINISH
  } gbl_state_e;

  // Magnitude of an 8-bit signed value; -128 gives 128.
  function automatic logic [7:0] mag8(input logic signed [7:0] v);
    logic signed [8:0] w;
    w = {v[7], v};
    return w[8] ? 8'(-w) : 8'(w);
  endfunction

endpackage
`default_nettype wire

// ===== src/gbl_frame_ram.sv =====
// Single-port synchronous RAM holding the frame store words.
// One access a cycle, registered read data; no dependencies.
`default_nettype none
module gbl_frame_ram #(
  parameter int DEPTH  = 768,
  parameter int DATA_W = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [DATA_W-1:0]        wdata_i,
  output logic      [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== src/glyph_row_blitter.sv =====
// Glyph row blitter: frame store of WIDTH x HEIGHT colour words with fill, draw and read.
// Depends on gbl_pkg and gbl_frame_ram.
//
// One input channel (in_valid_i / in_ready_o) carries a word per item and one output
// channel (out_valid_o / out_ready_i) returns exactly one result word per item.
// Items are handled one at a time; in_ready_o is high whenever no item is in progress,
// even while the previous result still sits in the output register.
// A fill writes every pixel through the single RAM port, one per cycle. A draw runs
// the accepting cycle, the set-up states ST_MOD_Y, ST_MOD_X and ST_ROW_BASE to reduce
// row and column by the constant modulo, then ST_DRAW at one glyph column per cycle,
// each a possible write on the RAM port, and ST_FINISH to hand over the result.
// A read issues the RAM read in the accepting cycle, captures it in ST_READ_WAIT and hands
// it over in ST_FINISH; an unused kind or out-of-range read index goes to ST_FINISH.
// The result appears in the output register the cycle after the item finishes, provided
// the register is empty or being emptied; if the receiver stalls, the finished result
// waits internally and no new item is taken until it has moved on.
// Reset clears the control state only; the frame store holds nothing defined until it
// has been written, and there is no clearing pass.
`default_nettype none
module glyph_row_blitter
  import gbl_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [1:0]         kind_i,
  input  wire logic [7:0]         row_bits_i,
  input  wire logic signed [7:0]  pos_x_i,
  input  wire logic signed [7:0]  pos_y_i,
  input  wire logic [31:0]        color_i,
  input  wire logic               wrap_x_i,
  input  wire logic               wrap_y_i,
  input  wire logic [9:0]         pixel_index_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [31:0]             read_color_o,
  output logic                    is_read_o
);

  gbl_state_e state_q, state_d;

  logic [7:0]         bits_q, bits_d;
  logic signed [7:0]  px_q, px_d;
  logic signed [7:0]  py_q, py_d;
  logic [COLOR_W-1:0] color_q, color_d;
  logic               wrap_x_q, wrap_x_d;
  logic               wrap_y_q, wrap_y_d;
  logic [ADDR_W-1:0]  addr_q, addr_d;
  logic [7:0]         quot_q, quot_d;
  logic signed [8:0]  row_q, row_d;
  logic               row_ok_q, row_ok_d;
  logic [ADDR_W-1:0]  row_base_q, row_base_d;
  logic signed [8:0]  v_q, v_d;
  logic [COL_W-1:0]   rem_q, rem_d;
  logic [2:0]         cnt_q, cnt_d;
  logic [COLOR_W-1:0] res_color_q, res_color_d;
  logic               res_read_q, res_read_d;

  logic               out_valid_q, out_valid_d;
  logic [COLOR_W-1:0] out_color_q, out_color_d;
  logic               out_read_q, out_read_d;

  logic               ram_we, ram_re;
  logic [ADDR_W-1:0]  ram_addr;
  logic [COLOR_W-1:0] ram_rdata;

  logic [23:0]        prod;
  logic [15:0]        rem_full;
  logic signed [8:0]  red9;
  logic signed [8:0]  col_s;
  logic               col_ok;

  gbl_frame_ram #(
    .DEPTH  (STORE_WORDS),
    .DATA_W (COLOR_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (color_q),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bits_q      <= bits_d;
    px_q        <= px_d;
    py_q        <= py_d;
    color_q     <= color_d;
    wrap_x_q    <= wrap_x_d;
    wrap_y_q    <= wrap_y_d;
    addr_q      <= addr_d;
    quot_q      <= quot_d;
    row_q       <= row_d;
    row_ok_q    <= row_ok_d;
    row_base_q  <= row_base_d;
    v_q         <= v_d;
    rem_q       <= rem_d;
    cnt_q       <= cnt_d;
    res_color_q <= res_color_d;
    res_read_q  <= res_read_d;
    out_color_q <= out_color_d;
    out_read_q  <= out_read_d;
  end

  // Column of the current glyph bit, reduced with the sign of the unreduced column.
  always_comb begin
    red9   = 9'(rem_q);
    col_s  = wrap_x_q ? (v_q[8] ? -red9 : red9) : v_q;
    col_ok = !col_s[8] && (col_s < WIDTH_S);
  end

  always_comb begin
    state_d     = state_q;
    bits_d      = bits_q;
    px_d        = px_q;
    py_d        = py_q;
    color_d     = color_q;
    wrap_x_d    = wrap_x_q;
    wrap_y_d    = wrap_y_q;
    addr_d      = addr_q;
    quot_d      = quot_q;
    row_d       = row_q;
    row_ok_d    = row_ok_q;
    row_base_d  = row_base_q;
    v_d         = v_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    res_color_d = res_color_q;
    res_read_d  = res_read_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    out_color_d = out_color_q;
    out_read_d  = out_read_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_addr    = addr_q;
    in_ready_o  = 1'b0;
    prod        = '0;
    rem_full    = '0;

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          bits_d      = row_bits_i;
          px_d        = pos_x_i;
          py_d        = pos_y_i;
          color_d     = color_i;
          wrap_x_d    = wrap_x_i;
          wrap_y_d    = wrap_y_i;
          res_color_d = '0;
          res_read_d  = 1'b0;
          case (kind_i)
            KIND_FILL: begin
              addr_d  = '0;
              state_d = ST_FILL;
            end
            KIND_DRAW: begin
              state_d = ST_MOD_Y;
            end
            KIND_READ: begin
              res_read_d = 1'b1;
              if ({1'b0, pixel_index_i} < 11'(STORE_WORDS)) begin
                ram_re   = 1'b1;
                ram_addr = ADDR_W'(pixel_index_i);
                state_d  = ST_READ_WAIT;
              end else begin
                state_d = ST_FINISH;
              end
            end
            default: begin
              state_d = ST_FINISH;
            end
          endcase
        end
      end

      ST_FILL: begin
        ram_we = 1'b1;
        addr_d = addr_q + 1'b1;
        if (addr_q == LAST_ADDR) begin
          state_d = ST_FINISH;
        end
      end

      ST_MOD_Y: begin
        prod    = 24'(mag8(py_q) * RCP_H);
        quot_d  = prod[RCP_SH+7:RCP_SH];
        state_d = ST_MOD_X;
      end

      ST_MOD_X: begin
        rem_full = {8'd0, mag8(py_q)} - 16'(quot_q * HEIGHT);
        if (rem_full >= 16'(HEIGHT)) begin
          rem_full = rem_full - 16'(HEIGHT);
        end
        if (wrap_y_q) begin
          row_d = py_q[7] ? -(9'(rem_full[7:0])) : 9'(rem_full[7:0]);
        end else begin
          row_d = {py_q[7], py_q};
        end
        prod    = 24'(mag8(px_q) * RCP_W);
        quot_d  = prod[RCP_SH+7:RCP_SH];
        state_d = ST_ROW_BASE;
      end

      ST_ROW_BASE: begin
        rem_full = {8'd0, mag8(px_q)} - 16'(quot_q * WIDTH);
        if (rem_full >= 16'(WIDTH)) begin
          rem_full = rem_full - 16'(WIDTH);
        end
        rem_d      = COL_W'(rem_full);
        v_d        = {px_q[7], px_q};
        row_ok_d   = !row_q[8] && (row_q < HEIGHT_S);
        row_base_d = ADDR_W'(row_q[7:0] * WIDTH);
        cnt_d      = '0;
        state_d    = ST_DRAW;
      end

      ST_DRAW: begin
        if (((bits_q & LEFT_MASK) != 8'd0) && row_ok_q && col_ok) begin
          ram_we   = 1'b1;
          ram_addr = row_base_q + ADDR_W'(col_s[7:0]);
        end
        bits_d = bits_q << 1;
        v_d    = v_q + 9'sd1;
        // Stepping the column moves the magnitude up when non-negative, down otherwise.
        if (!v_q[8]) begin
          rem_d = (rem_q == COL_W'(WIDTH - 1)) ? '0 : rem_q + 1'b1;
        end else begin
          rem_d = (rem_q == '0) ? COL_W'(WIDTH - 1) : rem_q - 1'b1;
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 3'(GLYPH_COLS - 1)) begin
          state_d = ST_FINISH;
        end
      end

      ST_READ_WAIT: begin
        res_color_d = ram_rdata;
        state_d     = ST_FINISH;
      end

      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_color_d = res_color_q;
          out_read_d  = res_read_q;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o  = out_valid_q;
  assign read_color_o = out_color_q;
  assign is_read_o    = out_read_q;

endmodule
`default_nettype wire

// ===== src/gbl_chk.sv =====
// Port-level checker for the glyph row blitter, bound to the top level.
// Depends on gbl_pkg for the item kinds and the store size.
`default_nettype none
module gbl_chk
  import gbl_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic [1:0]  kind_i,
  input wire logic [9:0]  pixel_index_i,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [31:0] read_color_o,
  input wire logic        is_read_o
);

  logic in_acc;
  logic quick_item;

  assign in_acc = in_valid_i && in_ready_o;
  // Items that touch no pixel finish straight away.
  assign quick_item = (kind_i != KIND_FILL && kind_i != KIND_DRAW && kind_i != KIND_READ) ||
                      (kind_i == KIND_READ && {1'b0, pixel_index_i} >= 11'(STORE_WORDS));

  // A stalled result word stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(read_color_o) && $stable(is_read_o))
    else $error("result word changed while stalled");

  // Only a read answer may carry a colour.
  a_zero_colour: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_read_o |-> read_color_o == 32'd0)
    else $error("non-read result carries a colour");

  // One item at a time: an accepted word closes the input for the next cycle.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_o)
    else $error("input accepted while an item is in progress");

  // An item that needs no memory work goes straight to ST_FINISH; a result word is on show once that state has passed.
  a_quick_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && quick_item |=> ##1 out_valid_o)
    else $error("quick item produced no result");

endmodule

bind glyph_row_blitter gbl_chk u_gbl_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .kind_i        (kind_i),
  .pixel_index_i (pixel_index_i),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .read_color_o  (read_color_o),
  .is_read_o     (is_read_o)
);
`default_nettype wire

// ===== tb/glyph_row_blitter_test.sv =====
// Self-checking testbench for glyph_row_blitter: fill, glyph row draw and pixel read words.
// Depends on gbl_pkg and the glyph_row_blitter RTL; a scoreboard class keeps a copy of the store.
`default_nettype none
module glyph_row_blitter_test;
  import gbl_pkg::*;

  localparam logic [1:0] KIND_SPARE = 2'd3;
  localparam int ITEMS         = 1750;
  localparam int CALM_FROM     = 700;
  localparam int CALM_TO       = 1000;
  localparam int SETTLE_CYCLES = 40;
  localparam int LIMIT_TIME    = 6_000_000;

  typedef struct {
    logic [1:0]        kind;
    logic [7:0]        row_bits;
    logic signed [7:0] pos_x;
    logic signed [7:0] pos_y;
    logic [31:0]       color;
    logic              wrap_x;
    logic              wrap_y;
    logic [9:0]        pixel_index;
  } glyph_word_t;

  typedef struct {
    logic [31:0] read_color;
    logic        is_read;
  } pixel_answer_t;

  class blit_scoreboard;
    logic [31:0]   pixels [STORE_WORDS];
    pixel_answer_t pending [$];
    int            errors;

    function new();
      errors = 0;
    endfunction

    // Apply one accepted word to the store copy and queue the answer it must produce.
    function void note_word(glyph_word_t w);
      pixel_answer_t a;
      int row;
      int col;
      a.read_color = '0;
      a.is_read    = 1'b0;
      case (w.kind)
        KIND_FILL: begin
          foreach (pixels[i]) pixels[i] = w.color;
        end
        KIND_DRAW: begin
          // The modulo truncates towards zero, so a negative position stays off screen.
          row = w.wrap_y ? ($signed(w.pos_y) % HEIGHT) : $signed(w.pos_y);
          if (row >= 0 && row < HEIGHT) begin
            for (int i = 0; i < GLYPH_COLS; i++) begin
              if (w.row_bits[GLYPH_COLS-1-i]) begin
                col = $signed(w.pos_x) + i;
                if (w.wrap_x) col = col % WIDTH;
                if (col >= 0 && col < WIDTH) pixels[row*WIDTH + col] = w.color;
              end
            end
          end
        end
        KIND_READ: begin
          a.is_read = 1'b1;
          if (w.pixel_index < STORE_WORDS) a.read_color = pixels[w.pixel_index];
        end
        default: ;
      endcase
      pending.push_back(a);
    endfunction

    function void check_word(logic [31:0] read_color, logic is_read);
      pixel_answer_t e;
      if (pending.size() == 0) begin
        errors++;
        $error("result word with nothing expected: read_color %h is_read %b",
               read_color, is_read);
        return;
      end
      e = pending.pop_front();
      if (read_color !== e.read_color) begin
        errors++;
        $error("read_color: expected %h, actual %h", e.read_color, read_color);
      end
      if (is_read !== e.is_read) begin
        errors++;
        $error("is_read: expected %b, actual %b", e.is_read, is_read);
      end
    endfunction
  endclass

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              in_valid_i    = 1'b0;
  logic              in_ready_o;
  logic [1:0]        kind_i        = '0;
  logic [7:0]        row_bits_i    = '0;
  logic signed [7:0] pos_x_i       = '0;
  logic signed [7:0] pos_y_i       = '0;
  logic [31:0]       color_i       = '0;
  logic              wrap_x_i      = 1'b0;
  logic              wrap_y_i      = 1'b0;
  logic [9:0]        pixel_index_i = '0;
  logic              out_valid_o;
  logic              out_ready_i   = 1'b0;
  logic [31:0]       read_color_o;
  logic              is_read_o;

  bit             calm = 1'b0;
  blit_scoreboard sb   = new();

  glyph_row_blitter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .kind_i        (kind_i),
    .row_bits_i    (row_bits_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .color_i       (color_i),
    .wrap_x_i      (wrap_x_i),
    .wrap_y_i      (wrap_y_i),
    .pixel_index_i (pixel_index_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .read_color_o  (read_color_o),
    .is_read_o     (is_read_o)
  );

  always #6 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_ready_i = calm || ($urandom_range(99) >= 15);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_word(read_color_o, is_read_o);
  end

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_word(input glyph_word_t w);
    while (!calm && $urandom_range(99) < 15) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    kind_i        = w.kind;
    row_bits_i    = w.row_bits;
    pos_x_i       = w.pos_x;
    pos_y_i       = w.pos_y;
    color_i       = w.color;
    wrap_x_i      = w.wrap_x;
    wrap_y_i      = w.wrap_y;
    pixel_index_i = w.pixel_index;
    in_valid_i    = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_word(w);
    @(negedge clk_i);
  endtask

  task automatic put(input logic [1:0] k, input logic [7:0] bits,
                     input logic signed [7:0] x, input logic signed [7:0] y,
                     input logic [31:0] c, input logic wx, input logic wy,
                     input logic [9:0] idx);
    glyph_word_t w;
    w.kind        = k;
    w.row_bits    = bits;
    w.pos_x       = x;
    w.pos_y       = y;
    w.color       = c;
    w.wrap_x      = wx;
    w.wrap_y      = wy;
    w.pixel_index = idx;
    send_word(w);
  endtask

  initial begin
    #(LIMIT_TIME);
    $display("glyph_row_blitter_test: errors");
    $finish;
  end

  initial begin
    glyph_word_t w;
    int          pick;
    int          row;
    int          px;
    int          aim_row;
    int          aim_col;
    aim_row = 0;
    aim_col = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // The store is undefined until written, so a fill always comes first.
    put(KIND_FILL, 8'h00, 8'sd0, 8'sd0, 32'h0000_0000, 1'b0, 1'b0, 10'd0);
    put(KIND_READ, 8'hff, -8'sd1, -8'sd1, 32'hffff_ffff, 1'b1, 1'b1, 10'd767);
    put(KIND_FILL, 8'hff, -8'sd128, 8'sd127, 32'hffff_ffff, 1'b1, 1'b1, 10'd1023);
    put(KIND_READ, 8'h00, 8'sd0, 8'sd0, 32'h0, 1'b0, 1'b0, 10'd0);
    put(KIND_READ, 8'h00, 8'sd0, 8'sd0, 32'h0, 1'b0, 1'b0, 10'd768);
    put(KIND_READ, 8'h00, 8'sd0, 8'sd0, 32'h0, 1'b0, 1'b0, 10'd1023);
    put(KIND_DRAW, 8'hff, 8'sd0, 8'sd0, 32'h1122_3344, 1'b0, 1'b0, 10'd0);
    put(KIND_DRAW, 8'h81, 8'sd24, 8'sd23, 32'haabb_ccdd, 1'b0, 1'b0, 10'd0);
    put(KIND_DRAW, 8'hff, -8'sd3, 8'sd5, 32'h0000_00ff, 1'b0, 1'b0, 10'd0);
    put(KIND_DRAW, 8'hff, 8'sd28, 8'sd6, 32'h0000_ff00, 1'b1, 1'b0, 10'd0);
    put(KIND_DRAW, 8'hff, -8'sd5, 8'sd7, 32'h00ff_0000, 1'b1, 1'b0, 10'd0);
    put(KIND_DRAW, 8'hff, 8'sd127, 8'sd127, 32'h5a5a_5a5a, 1'b1, 1'b1, 10'd0);
    put(KIND_DRAW, 8'hff, -8'sd128, -8'sd128, 32'hdead_beef, 1'b1, 1'b1, 10'd0);
    put(KIND_DRAW, 8'hff, 8'sd8, 8'sd24, 32'hdead_beef, 1'b0, 1'b0, 10'd0);
    put(KIND_DRAW, 8'hff, 8'sd8, -8'sd1, 32'hdead_beef, 1'b0, 1'b1, 10'd0);
    put(KIND_DRAW, 8'h3c, 8'sd8, 8'sd47, 32'h0f0f_0f0f, 1'b0, 1'b1, 10'd0);
    put(KIND_DRAW, 8'h00, 8'sd0, 8'sd0, 32'h0, 1'b0, 1'b0, 10'd0);
    put(KIND_SPARE, 8'hff, -8'sd1, -8'sd1, 32'hffff_ffff, 1'b1, 1'b1, 10'd1023);
    put(KIND_READ, 8'h00, 8'sd0, 8'sd0, 32'h0, 1'b0, 1'b0, 10'd7);
    put(KIND_READ, 8'h00, 8'sd0, 8'sd0, 32'h0, 1'b0, 1'b0, 10'(23*WIDTH + 24));
    put(KIND_READ, 8'h00, 8'sd0, 8'sd0, 32'h0, 1'b0, 1'b0, 10'(5*WIDTH));
    put(KIND_READ, 8'h00, 8'sd0, 8'sd0, 32'h0, 1'b0, 1'b0, 10'(6*WIDTH + 31));
    put(KIND_READ, 8'h00, 8'sd0, 8'sd0, 32'h0, 1'b0, 1'b0, 10'(7*WIDTH + 2));
    put(KIND_READ, 8'h00, 8'sd0, 8'sd0, 32'h0, 1'b0, 1'b0, 10'(7*WIDTH + 31));
    put(KIND_READ, 8'h00, 8'sd0, 8'sd0, 32'h0, 1'b0, 1'b0, 10'(23*WIDTH + 10));

    for (int n = 0; n < ITEMS; n++) begin
      calm          = (n >= CALM_FROM && n < CALM_TO);
      w.row_bits    = 8'($urandom);
      w.pos_x       = 8'($urandom);
      w.pos_y       = 8'($urandom);
      w.color       = $urandom;
      w.wrap_x      = 1'($urandom);
      w.wrap_y      = 1'($urandom);
      w.pixel_index = 10'($urandom);
      pick = $urandom_range(999);
      if (pick < 8) begin
        w.kind = KIND_FILL;
      end else if (pick < 30) begin
        w.kind = KIND_SPARE;
      end else if (pick < 560) begin
        w.kind = KIND_DRAW;
        // Mostly land near the screen so that clipping and wrapping edges get exercised.
        if ($urandom_range(9) < 7) begin
          w.pos_x = 8'(int'($urandom_range(47)) - 8);
          w.pos_y = 8'(int'($urandom_range(31)) - 4);
        end
        px  = $signed(w.pos_x);
        row = w.wrap_y ? ($signed(w.pos_y) % HEIGHT) : $signed(w.pos_y);
        if (row >= 0 && row < HEIGHT) begin
          aim_row = row;
          aim_col = (px < 0) ? 0 : ((px >= WIDTH) ? WIDTH - GLYPH_COLS : px);
        end
      end else begin
        w.kind = KIND_READ;
        pick = $urandom_range(9);
        if (pick < 6)
          w.pixel_index = 10'(aim_row*WIDTH + (aim_col + int'($urandom_range(7))) % WIDTH);
        else if (pick < 9)
          w.pixel_index = 10'($urandom_range(STORE_WORDS - 1));
      end
      send_word(w);
    end
    in_valid_i = 1'b0;
    calm       = 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("glyph_row_blitter_test: clean");
    end else begin
      $display("glyph_row_blitter_test: errors");
    end
    $finish;
  end

endmodule
`default_nettype wire
